>>> sv/tls_sni_pkg.sv
// Package for the TLS ClientHello SNI extractor: payload structs, status codes, limits.
// No dependencies.
`default_nettype none
package tls_sni_pkg;
    localparam int unsigned POS_W = 17;
    localparam logic [POS_W-1:0] CAPTURE_LIMIT_RESET = 17'd16384;
    localparam logic [7:0] MAX_NAME_LEN_RESET = 8'd255;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NAME_LEN = 1'b1;

    typedef enum logic [2:0] {
        ST_PARSED   = 3'd0,
        ST_MISSING  = 3'd1,
        ST_NOT_TLS  = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_TOO_LONG = 3'd4,
        ST_ERR      = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
    } sni_in_t;

    typedef struct packed {
        logic       name_valid;
        logic [7:0] name_byte;
        logic       name_last;
        logic       status_valid;
        logic [2:0] status;
    } sni_out_t;
endpackage
`default_nettype wire

>>> sv/tls_client_hello_sni_extractor.sv
// Top level: byte-serial ClientHello walker that streams the SNI host name and a verdict.
// Depends on tls_sni_pkg.
//
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | sni_in_t  (data_byte, stream_start)
// out     | out | out_valid/out_ready| sni_out_t (name and status)
// cfg     | in  | cfg_we             | cfg_index, cfg_data (17 bits)
//
// One byte per cycle while in_ready is high; each accepted byte updates the phase and position registers.
// Results sit in a single output register; a new byte is taken while it is empty or
// being drained in the same cycle. Reset leaves the parser at the record header.
`default_nettype none
module tls_client_hello_sni_extractor
    import tls_sni_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sni_in_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output sni_out_t                  out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [POS_W-1:0]     cfg_data
);
    typedef enum logic [4:0] {
        PH_TYPE, PH_VMAJ, PH_VMIN, PH_RLEN, PH_HTYPE, PH_HLEN, PH_RANDOM,
        PH_SIDLEN, PH_SKIP_SID, PH_CSLEN, PH_SKIP_CS, PH_CMLEN, PH_SKIP_CM,
        PH_EXTLEN, PH_EXTTYPE, PH_EXTSIZE, PH_SKIP_EXT, PH_LISTLEN, PH_NAMEHDR,
        PH_SKIP_NAME, PH_NAME, PH_WAIT,
        PH_D_SID, PH_D_CM, PH_D_EXT, PH_D_EXTLOOP, PH_D_NAMELOOP
    } phase_t;

    logic [POS_W-1:0] cap_reg;
    logic [7:0]       maxlen_reg;
    logic [POS_W-1:0] seen_reg, seen_next;
    phase_t           ph_reg, ph_next;
    logic             fin_reg, fin_next;
    logic [POS_W-1:0] rec_reg, rec_next, hs_reg, hs_next, exts_reg, exts_next;
    logic [POS_W-1:0] ext_reg, ext_next, nl_reg, nl_next;
    logic [23:0]      acc_reg, acc_next;
    logic [15:0]      skip_reg, skip_next;
    status_t          pst_reg, pst_next;
    logic             pv_reg, pv_next;
    logic             ov_reg;
    sni_out_t         od_reg;

    logic             accept;
    assign in_ready  = !ov_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    function automatic logic host_char(input logic [7:0] c);
        host_char = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                    (c >= 8'h61 && c <= 8'h7A) || c == 8'h2D || c == 8'h2E;
    endfunction

    logic             name_out, name_end, st_out;
    status_t          st;
    logic [7:0]       b;
    logic [POS_W+1:0] p;
    logic [23:0]      v;
    logic [15:0]      sk;
    logic [POS_W+1:0] n;
    logic             active;

    always_comb
    begin
        b = in_data.data_byte;
        seen_next = seen_reg; ph_next = ph_reg; fin_next = fin_reg;
        rec_next = rec_reg; hs_next = hs_reg; exts_next = exts_reg;
        ext_next = ext_reg; nl_next = nl_reg; acc_next = acc_reg;
        skip_next = skip_reg; pst_next = pst_reg; pv_next = pv_reg;
        if (in_data.stream_start)
        begin
            seen_next = '0; ph_next = PH_TYPE; fin_next = 1'b0;
            rec_next = '0; hs_next = '0; exts_next = '0; ext_next = '0; nl_next = '0;
            acc_next = '0; skip_next = '0; pst_next = ST_PARSED; pv_next = 1'b0;
        end
        active = !fin_next;
        name_out = 1'b0; name_end = 1'b0; st_out = 1'b0; st = ST_PARSED;
        v = '0; sk = '0; n = '0;
        seen_next = active ? seen_next + 1'b1 : seen_next;
        p = {2'b00, seen_next};
        if (active)
        begin
            unique case (ph_next)
                PH_TYPE:
                    if (b != 8'h16) begin st_out = 1'b1; st = ST_NOT_TLS; end
                    else ph_next = PH_VMAJ;
                PH_VMAJ:
                begin
                    if (b != 8'h03) begin pv_next = 1'b1; pst_next = ST_ERR; end
                    ph_next = PH_VMIN;
                end
                PH_VMIN:
                begin
                    ph_next = PH_RLEN; skip_next = 16'd2; acc_next = '0;
                end
                PH_WAIT: ;
                PH_RANDOM, PH_SKIP_SID, PH_SKIP_CS, PH_SKIP_CM, PH_SKIP_EXT,
                PH_SKIP_NAME:
                begin
                    skip_next = skip_next - 1'b1;
                    if (skip_next == '0)
                    begin
                        unique case (ph_next)
                            PH_RANDOM:
                            begin
                                ph_next = PH_SIDLEN; skip_next = 16'd1; acc_next = '0;
                            end
                            PH_SKIP_SID: ph_next = PH_D_SID;
                            PH_SKIP_CS:  ph_next = PH_D_CM;
                            PH_SKIP_CM:  ph_next = PH_D_EXT;
                            PH_SKIP_EXT: ph_next = PH_D_EXTLOOP;
                            default:     ph_next = PH_D_NAMELOOP;
                        endcase
                    end
                end
                PH_NAME:
                    if (host_char(b))
                    begin
                        name_out = 1'b1;
                        skip_next = skip_next - 1'b1;
                        if (skip_next == '0)
                        begin
                            name_end = 1'b1; pst_next = ST_PARSED; pv_next = 1'b1;
                            ph_next = PH_WAIT;
                        end
                    end
                    else
                    begin
                        pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                    end
                default:
                begin
                    acc_next = {acc_next[15:0], b};
                    skip_next = skip_next - 1'b1;
                    v = acc_next;
                    sk = v[15:0];
                    n = {{(POS_W+2-16){1'b0}}, sk};
                    if (skip_next == '0)
                    begin
                        unique case (ph_next)
                            PH_RLEN:
                                if (pv_next || v == '0) begin st_out = 1'b1; st = ST_ERR; end
                                else
                                begin
                                    rec_next = POS_W'(17'd5 + POS_W'(sk));
                                    if (sk < 16'd4)
                                    begin
                                        pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                                    end
                                    else
                                    begin
                                        ph_next = PH_HTYPE; skip_next = 16'd1; acc_next = '0;
                                    end
                                end
                            PH_HTYPE:
                                if (v != 24'h1)
                                begin
                                    pst_next = ST_NOT_TLS; pv_next = 1'b1; ph_next = PH_WAIT;
                                end
                                else
                                begin
                                    ph_next = PH_HLEN; skip_next = 16'd3; acc_next = '0;
                                end
                            PH_HLEN:
                                if (v == '0 || {1'b0, v} + 25'd9 > {8'd0, rec_next})
                                begin
                                    pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                                end
                                else
                                begin
                                    hs_next = POS_W'(v + 24'd9);
                                    if (p + 19'd35 > {2'b00, hs_next})
                                    begin
                                        pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                                    end
                                    else
                                    begin
                                        ph_next = PH_RANDOM; skip_next = 16'd34;
                                    end
                                end
                            PH_SIDLEN, PH_CSLEN, PH_CMLEN:
                                if (p + n > {2'b00, hs_next} ||
                                    (ph_next != PH_SIDLEN && sk == '0) ||
                                    (ph_next == PH_CSLEN && sk[0]))
                                begin
                                    pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                                end
                                else if (sk == '0)
                                    ph_next = PH_D_SID;
                                else
                                begin
                                    skip_next = sk;
                                    ph_next = (ph_next == PH_SIDLEN) ? PH_SKIP_SID :
                                              (ph_next == PH_CSLEN) ? PH_SKIP_CS : PH_SKIP_CM;
                                end
                            PH_EXTLEN:
                                if (p + n != {2'b00, hs_next})
                                begin
                                    pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                                end
                                else
                                begin
                                    exts_next = hs_next; ph_next = PH_D_EXTLOOP;
                                end
                            PH_EXTTYPE:
                            begin
                                ph_next = PH_EXTSIZE; skip_next = 16'd2;
                                acc_next = {23'd0, v != '0};
                            end
                            PH_EXTSIZE:
                                if (p + n > {2'b00, exts_next})
                                begin
                                    pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                                end
                                else
                                begin
                                    ext_next = POS_W'(p + n);
                                    if (v[16])
                                    begin
                                        if (sk == '0) ph_next = PH_D_EXTLOOP;
                                        else begin ph_next = PH_SKIP_EXT; skip_next = sk; end
                                    end
                                    else if (sk < 16'd2)
                                    begin
                                        pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                                    end
                                    else
                                    begin
                                        ph_next = PH_LISTLEN; skip_next = 16'd2; acc_next = '0;
                                    end
                                end
                            PH_LISTLEN:
                                if (p + n != {2'b00, ext_next})
                                begin
                                    pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                                end
                                else
                                begin
                                    nl_next = POS_W'(p + n); ph_next = PH_D_NAMELOOP;
                                end
                            default:
                                if (p + n > {2'b00, nl_next})
                                begin
                                    pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                                end
                                else if (v[23:16] != '0)
                                begin
                                    if (sk == '0) ph_next = PH_D_NAMELOOP;
                                    else begin ph_next = PH_SKIP_NAME; skip_next = sk; end
                                end
                                else if (sk > {8'd0, maxlen_reg})
                                begin
                                    pst_next = ST_TOO_LONG; pv_next = 1'b1; ph_next = PH_WAIT;
                                end
                                else if (sk == '0)
                                begin
                                    pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                                end
                                else
                                begin
                                    ph_next = PH_NAME; skip_next = sk;
                                end
                        endcase
                    end
                end
            endcase
            // decision points; at most one is resolved per byte, and none chains into another
            if (ph_next == PH_D_SID)
            begin
                if (p + 19'd2 > {2'b00, hs_next})
                begin
                    pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                end
                else
                begin
                    ph_next = PH_CSLEN; skip_next = 16'd2; acc_next = '0;
                end
            end
            else if (ph_next == PH_D_CM)
            begin
                if (p + 19'd1 > {2'b00, hs_next})
                begin
                    pst_next = ST_ERR; pv_next = 1'b1; ph_next = PH_WAIT;
                end
                else
                begin
                    ph_next = PH_CMLEN; skip_next = 16'd1; acc_next = '0;
                end
            end
            else if (ph_next == PH_D_EXT)
            begin
                pv_next = 1'b1; ph_next = PH_WAIT;
                if (p == {2'b00, hs_next}) pst_next = ST_MISSING;
                else if (p + 19'd2 > {2'b00, hs_next}) pst_next = ST_ERR;
                else
                begin
                    pv_next = pv_reg && !in_data.stream_start;
                    ph_next = PH_EXTLEN; skip_next = 16'd2; acc_next = '0;
                end
            end
            else if (ph_next == PH_D_EXTLOOP)
            begin
                if (p + 19'd4 <= {2'b00, exts_next})
                begin
                    ph_next = PH_EXTTYPE; skip_next = 16'd2; acc_next = '0;
                end
                else
                begin
                    pv_next = 1'b1; ph_next = PH_WAIT;
                    pst_next = (p != {2'b00, exts_next}) ? ST_ERR : ST_MISSING;
                end
            end
            else if (ph_next == PH_D_NAMELOOP)
            begin
                if (p + 19'd3 <= {2'b00, nl_next})
                begin
                    ph_next = PH_NAMEHDR; skip_next = 16'd3; acc_next = '0;
                end
                else
                begin
                    pv_next = 1'b1; ph_next = PH_WAIT; pst_next = ST_MISSING;
                end
            end
            if (!st_out)
            begin
                if (rec_next != '0 && seen_next == rec_next)
                begin
                    st_out = 1'b1; st = pv_next ? pst_next : ST_ERR;
                end
                else if (seen_next >= cap_reg)
                begin
                    st_out = 1'b1; st = ST_TRUNC;
                end
            end
            if (st_out) fin_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAPTURE_LIMIT_RESET; maxlen_reg <= MAX_NAME_LEN_RESET;
            seen_reg <= '0; ph_reg <= PH_TYPE; fin_reg <= 1'b0;
            rec_reg <= '0; hs_reg <= '0; exts_reg <= '0; ext_reg <= '0; nl_reg <= '0;
            acc_reg <= '0; skip_reg <= '0; pst_reg <= ST_PARSED; pv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_CAPTURE_LIMIT) cap_reg <= cfg_data;
                else maxlen_reg <= cfg_data[7:0];
            end
            if (accept && (name_out || st_out)) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            if (accept)
            begin
                seen_reg <= seen_next; ph_reg <= ph_next; fin_reg <= fin_next;
                rec_reg <= rec_next; hs_reg <= hs_next; exts_reg <= exts_next;
                ext_reg <= ext_next; nl_reg <= nl_next; acc_reg <= acc_next;
                skip_reg <= skip_next; pst_reg <= pst_next; pv_reg <= pv_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (name_out || st_out))
        begin
            od_reg.name_valid   <= name_out;
            od_reg.name_byte    <= name_out ? b : 8'd0;
            od_reg.name_last    <= name_end;
            od_reg.status_valid <= st_out;
            od_reg.status       <= st_out ? st : ST_PARSED;
        end
    end

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ready |=> ov_reg && $stable(od_reg))
        else $error("pending result lost");
    a_fin_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && fin_reg && !in_data.stream_start |=> $stable(seen_reg))
        else $error("finished stream advanced");
    a_last_name: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && od_reg.name_last |-> od_reg.name_valid)
        else $error("name_last without name");
endmodule
`default_nettype wire
